/* sv/rrnet_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring route nearest-endpoint table package
// Shared widths, codes, the stored path entry and the control bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrnet_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned AddrW         = 31;
  localparam int unsigned KindW         = 2;
  localparam int unsigned CountW        = 5;
  localparam int unsigned GapW          = AddrW + 1;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One stored path. The path id is never read back, so it is not kept.
  typedef struct packed {
    logic [AddrW-1:0] end_a;
    logic [AddrW-1:0] end_b;
    logic [AddrW-1:0] hop_a;
    logic [AddrW-1:0] hop_b;
  } entry_t;

  typedef struct packed {
    logic start_item;
    logic append;
    logic flag_overflow;
    logic clear;
    logic scan_start;
    logic scan_issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic last_issue;
    logic exact_hit;
    logic pipe_busy;
  } dp_status_t;

endpackage : rrnet_pkg
`default_nettype wire

/* sv/rrnet_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring route nearest-endpoint table channels
// Request channel (append, clear, lookup) and response channel, each with a
// valid/ready handshake and its payload.
// ----------------------------------------------------------------------------
interface rrnet_req_if
  import rrnet_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [AddrW-1:0] dest;
  logic [AddrW-1:0] end_a;
  logic [AddrW-1:0] end_b;
  logic [AddrW-1:0] hop_a;
  logic [AddrW-1:0] hop_b;
  logic [AddrW-1:0] path_id;

  modport source (
    output valid, kind, dest, end_a, end_b, hop_a, hop_b, path_id,
    input  ready
  );
  modport sink (
    input  valid, kind, dest, end_a, end_b, hop_a, hop_b, path_id,
    output ready
  );
endinterface : rrnet_req_if

interface rrnet_rsp_if
  import rrnet_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  next_hop;
  logic              found;
  logic              overflow;
  logic [CountW-1:0] entry_count;

  modport source (
    output valid, next_hop, found, overflow, entry_count,
    input  ready
  );
  modport sink (
    input  valid, next_hop, found, overflow, entry_count,
    output ready
  );
endinterface : rrnet_rsp_if
`default_nettype wire

/* sv/ring_route_nearest_endpoint_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring route nearest-endpoint table
// Path table with append, clear and nearest-endpoint lookup of a next hop.
// ----------------------------------------------------------------------------
//   Port    Dir  Moves per transaction
//   req_i   in   kind, dest, end_a, end_b, hop_a, hop_b, path_id
//   rsp_o   out  next_hop, found, overflow, entry_count
//
// Append, clear and unused kinds, and a lookup of an empty table, go from
// acceptance straight to the done state. Other lookups read the single-port
// table one entry per cycle through a three-stage pipeline until the last
// entry or an exact endpoint match, then drain it. The done state waits for
// a free response register, loads it and returns to idle for the next request.
// Reset empties the table by clearing the entry count; no clearing pass.
// The response sits in its own register, so a new request is accepted while
// an earlier response waits on rsp_o.ready.
// ----------------------------------------------------------------------------
module ring_route_nearest_endpoint_table
  import rrnet_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrnet_req_if.sink   req_i,
  rrnet_rsp_if.source rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rrnet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rrnet_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .dest_i        (req_i.dest),
    .end_a_i       (req_i.end_a),
    .end_b_i       (req_i.end_b),
    .hop_a_i       (req_i.hop_a),
    .hop_b_i       (req_i.hop_b),
    .next_hop_o    (rsp_o.next_hop),
    .found_o       (rsp_o.found),
    .overflow_o    (rsp_o.overflow),
    .entry_count_o (rsp_o.entry_count)
  );

endmodule : ring_route_nearest_endpoint_table
`default_nettype wire

/* sv/rrnet_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring route nearest-endpoint table controller
// Sequences one request at a time: decodes the kind, runs the table scan for
// a lookup and hands the result to the response register.
// ----------------------------------------------------------------------------
module rrnet_ctrl
  import rrnet_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  wire logic [KindW-1:0] req_kind_i,
  output      logic             req_ready_o,
  output      logic             rsp_valid_o,
  input  wire logic             rsp_ready_i,
  input  wire dp_status_t       status_i,
  output      dp_cmd_t          cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   req_fire;
  logic   slot_free;
  kind_e  kind;

  assign kind        = kind_e'(req_kind_i);
  assign req_ready_o = (state_q == ST_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (kind == KIND_LOOKUP && !status_i.count_zero) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.exact_hit || status_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          cmd_o.start_item = 1'b1;
          case (kind)
            KIND_APPEND: begin
              cmd_o.append        = !status_i.full;
              cmd_o.flag_overflow = status_i.full;
            end
            KIND_CLEAR:  cmd_o.clear      = 1'b1;
            KIND_LOOKUP: cmd_o.scan_start = !status_i.count_zero;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = !status_i.exact_hit;
      end
      ST_DRAIN: ;
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          rsp_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule : rrnet_ctrl
`default_nettype wire

/* sv/rrnet_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring route nearest-endpoint table datapath
// Path table memory, entry count, the three-stage scan pipeline (read, gap,
// best update) and the response register.
// ----------------------------------------------------------------------------
module rrnet_dp
  import rrnet_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output      dp_status_t        status_o,
  input  wire logic [AddrW-1:0]  dest_i,
  input  wire logic [AddrW-1:0]  end_a_i,
  input  wire logic [AddrW-1:0]  end_b_i,
  input  wire logic [AddrW-1:0]  hop_a_i,
  input  wire logic [AddrW-1:0]  hop_b_i,
  output      logic [AddrW-1:0]  next_hop_o,
  output      logic              found_o,
  output      logic              overflow_o,
  output      logic [CountW-1:0] entry_count_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  entry_t           mem_q [TABLE_DEPTH];
  entry_t           rd_q;
  logic [CntW-1:0]  count_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [AddrW-1:0] dest_q;

  // Pipeline control bits.
  logic v1_q, v2_q, exact_q;

  // Gap stage registers.
  logic [AddrW-1:0] ga_q, gb_q, hop_a_q, hop_b_q;
  logic             eq_q;

  // Running best.
  logic [GapW-1:0]  best_gap_q;
  logic [AddrW-1:0] res_hop_q;
  logic             res_found_q, res_overflow_q;

  logic [AddrW-1:0] ga, gb, sel_hop;
  logic [GapW-1:0]  ga_ext, gb_ext, mid_gap;
  logic             ga_ok, gb_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[count_q[IdxW-1:0]] <= '{end_a: end_a_i, end_b: end_b_i,
                                    hop_a: hop_a_i, hop_b: hop_b_i};
    end
    if (cmd_i.scan_issue) begin
      rd_q <= mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      exact_q <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.clear) begin
        count_q <= '0;
      end
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      if (cmd_i.scan_start) begin
        exact_q <= 1'b0;
      end else if (v2_q && eq_q) begin
        exact_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_item) begin
      dest_q <= dest_i;
    end
    if (cmd_i.scan_start) begin
      rd_idx_q <= '0;
    end else if (cmd_i.scan_issue) begin
      rd_idx_q <= rd_idx_q + IdxW'(1);
    end
  end

  // Gap stage: absolute endpoint distances and exact match.
  assign ga = (rd_q.end_a >= dest_q) ? (rd_q.end_a - dest_q) : (dest_q - rd_q.end_a);
  assign gb = (rd_q.end_b >= dest_q) ? (rd_q.end_b - dest_q) : (dest_q - rd_q.end_b);

  always_ff @(posedge clk_i) begin
    ga_q    <= ga;
    gb_q    <= gb;
    eq_q    <= (rd_q.end_a == dest_q) || (rd_q.end_b == dest_q);
    hop_a_q <= rd_q.hop_a;
    hop_b_q <= rd_q.hop_b;
  end

  // Update stage. A is examined before B, and ties go to the later candidate.
  assign ga_ext  = {1'b0, ga_q};
  assign gb_ext  = {1'b0, gb_q};
  assign ga_ok   = ga_ext <= best_gap_q;
  assign mid_gap = ga_ok ? ga_ext : best_gap_q;
  assign gb_ok   = gb_ext <= mid_gap;
  assign sel_hop = (ga_q < gb_q) ? hop_a_q : hop_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_item) begin
      res_hop_q      <= '0;
      res_found_q    <= cmd_i.scan_start;
      res_overflow_q <= cmd_i.flag_overflow;
      best_gap_q     <= '1;
    end else if (v2_q && !exact_q) begin
      if (eq_q) begin
        res_hop_q <= sel_hop;
      end else if (ga_ok || gb_ok) begin
        res_hop_q  <= sel_hop;
        best_gap_q <= gb_ok ? gb_ext : ga_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      next_hop_o    <= res_hop_q;
      found_o       <= res_found_q;
      overflow_o    <= res_overflow_q;
      entry_count_o <= CountW'(count_q);
    end
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.full       = (count_q == CntW'(TABLE_DEPTH));
  assign status_o.last_issue = (CntW'(rd_idx_q) + CntW'(1)) == count_q;
  assign status_o.exact_hit  = exact_q;
  assign status_o.pipe_busy  = v1_q || v2_q;

endmodule : rrnet_dp
`default_nettype wire
